// ----- hw/rtl/btff_pkg.sv -----
// Shared types and constants of the block table first-fit allocator.
`default_nettype none

package btff_pkg;

  // Field and register widths
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned COUNT_W = 11;

  // Parameter defaults
  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned BLOCK_BYTES_DEF = 4096;

  // Register reset values
  localparam logic [ADDR_W-1:0]  HEAP_BASE_RST   = '0;
  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 11'd1024;

  // Table entry layout
  localparam int unsigned ENTRY_W        = 2;
  localparam int unsigned ENTRY_TAKEN    = 0;
  localparam int unsigned ENTRY_HAS_NEXT = 1;

  // Request codes
  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_HEAP_BASE   = 1'b0,
    CFG_BLOCK_COUNT = 1'b1
  } cfg_idx_e;

  // Controller states
  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_ADDR,
    S_DIV,
    S_FRD,
    S_FWR,
    S_OUT
  } state_e;

endpackage

`default_nettype wire

// ----- hw/rtl/btff_div.sv -----
// Block index of a 32-bit offset, a registered shift by the block size (a power of two).
`default_nettype none

module btff_div #(
  parameter int unsigned BLOCK_BYTES = btff_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [btff_pkg::ADDR_W-1:0] dividend_i,
  output logic                             done_o,
  output logic [btff_pkg::ADDR_W-1:0]      quot_o
);

  localparam int unsigned SH = $clog2(BLOCK_BYTES);

  logic                        done_q, done_d;
  logic [btff_pkg::ADDR_W-1:0] quot_q, quot_d;

  // Drop the byte offset within the block
  always_comb begin
    done_d = start_i;
    quot_d = quot_q;
    if (start_i) begin
      quot_d = dividend_i >> SH;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  // Hold datapath
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ----- hw/rtl/block_table_first_fit_allocator_unit.sv -----
// Top level of the block table first-fit allocator with its table memory.
// Allocate streams the table for the first free run that covers the size (one entry read per
//   cycle) and marks it; no memory if none fits; zero size is invalid. Free clears entries along
//   the chain from the address's block; an address out of range is invalid.
// One word at a time, ready again in the cycle after the last result enters the output reg once it is free.
// After reset the table is cleared with no word taken; config writes always taken.
`default_nettype none

module block_table_first_fit_allocator_unit #(
  parameter int unsigned TABLE_DEPTH = btff_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned BLOCK_BYTES = btff_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration write port
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_idx_i,
  input  wire logic [btff_pkg::ADDR_W-1:0]  cfg_data_i,
  // request channel
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         action_i,
  input  wire logic [btff_pkg::ADDR_W-1:0]  alloc_size_i,
  input  wire logic [btff_pkg::ADDR_W-1:0]  free_address_i,
  // result channel
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [btff_pkg::ADDR_W-1:0]       result_address_o,
  output logic [1:0]                        status_o
);

  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned BB_W  = $clog2(BLOCK_BYTES + 1);
  localparam int unsigned RB_W  = $clog2(TABLE_DEPTH) + $clog2(BLOCK_BYTES) + 1;
  localparam int unsigned CMP_W = (RB_W > btff_pkg::ADDR_W) ? RB_W : btff_pkg::ADDR_W;
  localparam int unsigned PW0   = CNT_W + BB_W;
  localparam int unsigned PW    = (PW0 > btff_pkg::ADDR_W) ? PW0 : btff_pkg::ADDR_W;
  localparam int unsigned EW    = btff_pkg::ENTRY_W;

  // Configuration registers
  logic [btff_pkg::ADDR_W-1:0]  heap_base_q;
  logic [btff_pkg::COUNT_W-1:0] block_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q   <= btff_pkg::HEAP_BASE_RST;
      block_count_q <= btff_pkg::BLOCK_COUNT_RST;
    end else if (cfg_we_i) begin
      case (btff_pkg::cfg_idx_e'(cfg_idx_i))
        btff_pkg::CFG_HEAP_BASE:   heap_base_q   <= cfg_data_i;
        btff_pkg::CFG_BLOCK_COUNT: block_count_q <= cfg_data_i[btff_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the block count to the table depth
  logic [CNT_W-1:0] n_use;
  assign n_use = (32'(block_count_q) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                         : CNT_W'(block_count_q);

  // Table memory: one write and one registered read per cycle
  logic [EW-1:0] mem_q [TABLE_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata;
  logic [EW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  // Offset to block index
  logic                        div_start, div_done;
  logic [btff_pkg::ADDR_W-1:0] div_quot;

  btff_div #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(free_address_i - heap_base_q),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // Controller registers
  btff_pkg::state_e            state_q, state_d;
  logic [CNT_W-1:0]            idx_q, idx_d;
  logic [CNT_W-1:0]            iss_q, iss_d;
  logic [CNT_W-1:0]            chk_q, chk_d;
  logic                        pend_q, pend_d;
  logic [CNT_W-1:0]            run_q, run_d;
  logic [RB_W-1:0]             rb_q, rb_d;
  logic [CNT_W-1:0]            start_q, start_d;
  logic [CNT_W-1:0]            end_q, end_d;
  logic [btff_pkg::ADDR_W-1:0] size_q, size_d;
  logic [btff_pkg::ADDR_W-1:0] prod_q, prod_d;
  logic [btff_pkg::ADDR_W-1:0] raddr_q, raddr_d;
  btff_pkg::status_e           rstat_q, rstat_d;
  logic                        ovalid_q, ovalid_d;
  logic [btff_pkg::ADDR_W-1:0] oaddr_q, oaddr_d;
  logic [1:0]                  ostat_q, ostat_d;

  logic             in_acc;
  logic [CNT_W-1:0] run_nx;
  logic [RB_W-1:0]  rb_nx;
  logic [PW-1:0]    prod_full;
  logic [CNT_W-1:0] idx_inc;

  assign in_ready_o = (state_q == btff_pkg::S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign div_start  = in_acc && (btff_pkg::action_e'(action_i) == btff_pkg::ACT_FREE);
  assign idx_inc    = idx_q + 1'b1;
  assign prod_full  = PW'(start_q) * PW'(BLOCK_BYTES);

  // Next state and memory control
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    iss_d     = iss_q;
    chk_d     = chk_q;
    pend_d    = pend_q;
    run_d     = run_q;
    rb_d      = rb_q;
    start_d   = start_q;
    end_d     = end_q;
    size_d    = size_q;
    prod_d    = prod_q;
    raddr_d   = raddr_q;
    rstat_d   = rstat_q;
    ovalid_d  = ovalid_q && !out_ready_i;
    oaddr_d   = oaddr_q;
    ostat_d   = ostat_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q[AW-1:0];
    mem_wdata = '0;
    mem_raddr = idx_q[AW-1:0];
    run_nx    = run_q + 1'b1;
    rb_nx     = rb_q + RB_W'(BLOCK_BYTES);

    case (state_q)
      // Clear the table after reset
      btff_pkg::S_CLR: begin
        mem_we = 1'b1;
        idx_d  = idx_inc;
        if (idx_q == CNT_W'(TABLE_DEPTH - 1)) begin
          idx_d   = '0;
          state_d = btff_pkg::S_IDLE;
        end
      end

      // Take a request word
      btff_pkg::S_IDLE: begin
        if (in_acc) begin
          raddr_d = '0;
          if (btff_pkg::action_e'(action_i) == btff_pkg::ACT_FREE) begin
            state_d = btff_pkg::S_DIV;
          end else if (alloc_size_i == '0) begin
            rstat_d = btff_pkg::ST_INVALID;
            state_d = btff_pkg::S_OUT;
          end else begin
            size_d  = alloc_size_i;
            iss_d   = '0;
            pend_d  = 1'b0;
            run_d   = '0;
            rb_d    = '0;
            state_d = btff_pkg::S_SCAN;
          end
        end
      end

      // Stream entries and track the current free run
      btff_pkg::S_SCAN: begin
        mem_raddr = iss_q[AW-1:0];
        if (iss_q < n_use) begin
          iss_d  = iss_q + 1'b1;
          pend_d = 1'b1;
          chk_d  = iss_q;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (!rdata_q[btff_pkg::ENTRY_TAKEN]) begin
            run_d = run_nx;
            rb_d  = rb_nx;
            if (CMP_W'(rb_nx) >= CMP_W'(size_q)) begin
              start_d = chk_q + 1'b1 - run_nx;
              idx_d   = chk_q + 1'b1 - run_nx;
              end_d   = chk_q;
              state_d = btff_pkg::S_MARK;
            end
          end else begin
            run_d = '0;
            rb_d  = '0;
          end
        end else if (iss_q >= n_use) begin
          rstat_d = btff_pkg::ST_NOMEM;
          state_d = btff_pkg::S_OUT;
        end
      end

      // Write the run as taken and chained
      btff_pkg::S_MARK: begin
        mem_we = 1'b1;
        mem_wdata[btff_pkg::ENTRY_TAKEN]    = 1'b1;
        mem_wdata[btff_pkg::ENTRY_HAS_NEXT] = (idx_q != end_q);
        prod_d = prod_full[btff_pkg::ADDR_W-1:0];
        idx_d  = idx_inc;
        if (idx_q == end_q) begin
          state_d = btff_pkg::S_ADDR;
        end
      end

      // Form the block address
      btff_pkg::S_ADDR: begin
        raddr_d = heap_base_q + prod_q;
        rstat_d = btff_pkg::ST_OK;
        state_d = btff_pkg::S_OUT;
      end

      // Wait for the block index and check its range
      btff_pkg::S_DIV: begin
        if (div_done) begin
          if (div_quot >= btff_pkg::ADDR_W'(n_use)) begin
            rstat_d = btff_pkg::ST_INVALID;
            state_d = btff_pkg::S_OUT;
          end else begin
            idx_d   = div_quot[CNT_W-1:0];
            state_d = btff_pkg::S_FRD;
          end
        end
      end

      // Read the first entry of the chain
      btff_pkg::S_FRD: begin
        state_d = btff_pkg::S_FWR;
      end

      // Clear one entry and read the next while the chain goes on
      btff_pkg::S_FWR: begin
        mem_we    = 1'b1;
        mem_raddr = idx_inc[AW-1:0];
        if (rdata_q[btff_pkg::ENTRY_HAS_NEXT] && (idx_inc < n_use)) begin
          idx_d = idx_inc;
        end else begin
          rstat_d = btff_pkg::ST_OK;
          state_d = btff_pkg::S_OUT;
        end
      end

      // Move the result into the output register once it is free
      btff_pkg::S_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          oaddr_d  = raddr_q;
          ostat_d  = rstat_q;
          state_d  = btff_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = btff_pkg::S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= btff_pkg::S_CLR;
      idx_q    <= '0;
      iss_q    <= '0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      iss_q    <= iss_d;
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Hold datapath
  always_ff @(posedge clk_i) begin
    chk_q   <= chk_d;
    run_q   <= run_d;
    rb_q    <= rb_d;
    start_q <= start_d;
    end_q   <= end_d;
    size_q  <= size_d;
    prod_q  <= prod_d;
    raddr_q <= raddr_d;
    rstat_q <= rstat_d;
    oaddr_q <= oaddr_d;
    ostat_q <= ostat_d;
  end

  assign out_valid_o      = ovalid_q;
  assign result_address_o = oaddr_q;
  assign status_o         = ostat_q;

endmodule

`default_nettype wire
